// ===== rtl/vns_pkg.sv =====
// ----------------------------------------------------------------------------
// vns_pkg: shared constants, types and weight table for value noise sampling
// Cosine weight ROM is built at elaboration from a fixed-point sine series.
// ----------------------------------------------------------------------------
package vns_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int COS_SIZE       = 1 << COS_TABLE_BITS;
  localparam int FRAC_BITS      = 36;

  localparam logic [31:0] HASH_KX  = 32'd271;
  localparam logic [31:0] HASH_KY  = 32'd1999;
  localparam logic [31:0] HASH_KZ  = 32'd3631;
  localparam logic [31:0] HASH_KC  = 32'd7919;
  localparam int          HASH_SH  = 13;
  localparam logic [31:0] HASH_M1  = 32'd41333;
  localparam logic [31:0] HASH_A1  = 32'd53307781;
  localparam logic [31:0] HASH_A2  = 32'd1376312589;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // sine series term divisors (2j)(2j+1)
  localparam longint unsigned SERIES_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156};

  // weight register depth between axis split and output multiply
  localparam int SIDE_DEPTH = 11;
  localparam int PIPE_DEPTH = 14;

  typedef logic [16:0] weight_t;
  typedef logic signed [31:0] q30_t;

  typedef struct packed {
    weight_t     wx;
    weight_t     wy;
    weight_t     wz;
    logic [23:0] amp;
  } side_t;

  typedef logic [16:0] rom_t [COS_SIZE];

  function automatic rom_t build_cos_rom();
    rom_t rom;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned f;
    longint s;
    for (int k = 0; k < COS_SIZE; k++) begin
      a    = (longint'(k) * HALF_PI_Q30) >> COS_TABLE_BITS;
      a2   = (a * a) >> 30;
      term = a;
      s    = longint'(a);
      for (int j = 1; j <= 6; j++) begin
        term = ((term * a2) >> 30) / SERIES_DIV[j-1];
        if ((j & 1) == 1) s = s - longint'(term);
        else              s = s + longint'(term);
      end
      if (s < 0) s = 0;
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      f = (longint'(s) * longint'(s) + (64'd1 << 43)) >> 44;
      if (f > 64'd65536) f = 64'd65536;
      rom[k] = 17'(f);
    end
    return rom;
  endfunction

  localparam rom_t COS_ROM = build_cos_rom();

endpackage

// ===== rtl/vns_if.sv =====
// ----------------------------------------------------------------------------
// vns_req_if / vns_rsp_if: sample request and result channels
// Valid/ready handshake, beat moves when both are high.
// ----------------------------------------------------------------------------
interface vns_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic signed [15:0] channel_seed;
  logic        [23:0] frequency;
  logic        [23:0] amplitude;
  modport source (output valid, coord_x, coord_y, coord_z, channel_seed, frequency,
                  amplitude, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, channel_seed, frequency,
                  amplitude, output ready);
endinterface

interface vns_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [26:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ===== rtl/vns_axis.sv =====
// ----------------------------------------------------------------------------
// vns_axis: one axis scale and split
// Stage 1 scales by frequency, stage 2 gives lattice corner and cosine weight.
// ----------------------------------------------------------------------------
module vns_axis (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [31:0]   coord,
  input  logic        [23:0]   freq,
  output logic        [31:0]   ipart,
  output vns_pkg::weight_t     w
);

  logic signed [56:0] p;
  logic        [55:0] mag;
  logic        [19:0] im;
  logic               neg;
  logic [vns_pkg::COS_TABLE_BITS-1:0] k;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= coord * $signed({1'b0, freq});
    end
  end

  always_comb begin
    neg = p[56];
    mag = neg ? 56'(-p) : p[55:0];
    im  = mag[55:vns_pkg::FRAC_BITS];
    k   = mag[vns_pkg::FRAC_BITS-1 -: vns_pkg::COS_TABLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ipart <= neg ? 32'(-{12'b0, im}) : {12'b0, im};
      w     <= vns_pkg::COS_ROM[k];
    end
  end

endmodule

// ===== rtl/vns_hash.sv =====
// ----------------------------------------------------------------------------
// vns_hash: lattice corner hash, four stages
// Wrapping 32-bit integer hash mapped to 1 - nn/2^30 in Q1.30.
// ----------------------------------------------------------------------------
module vns_hash (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   x,
  input  logic [31:0]   y,
  input  logic [31:0]   z,
  input  logic [31:0]   c,
  output vns_pkg::q30_t value
);

  logic [31:0] n0;
  logic [31:0] n1;
  logic [31:0] n2;
  logic [31:0] nsq;
  logic [31:0] t;
  logic [31:0] sum;
  logic [31:0] h;

  assign sum = x * vns_pkg::HASH_KX + y * vns_pkg::HASH_KY
             + z * vns_pkg::HASH_KZ + c * vns_pkg::HASH_KC;
  assign h   = n2 * t + vns_pkg::HASH_A2;

  always_ff @(posedge clk) begin
    if (en) begin
      n0    <= (sum << vns_pkg::HASH_SH) ^ sum;
      n1    <= n0;
      nsq   <= n0 * n0;
      n2    <= n1;
      t     <= nsq * vns_pkg::HASH_M1 + vns_pkg::HASH_A1;
      value <= vns_pkg::ONE_Q30 - $signed({1'b0, h[30:0]});
    end
  end

endmodule

// ===== rtl/vns_lerp.sv =====
// ----------------------------------------------------------------------------
// vns_lerp: weighted blend of two Q1.30 values, two stages
// Products registered, then summed and floor-shifted by 16.
// ----------------------------------------------------------------------------
module vns_lerp (
  input  logic             clk,
  input  logic             en,
  input  vns_pkg::q30_t    a,
  input  vns_pkg::q30_t    b,
  input  vns_pkg::weight_t w,
  output vns_pkg::q30_t    y
);

  logic signed [49:0] pa;
  logic signed [49:0] pb;
  logic signed [50:0] s;

  assign s = 51'(pa) + 51'(pb);

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= 50'(a * $signed({1'b0, 17'(17'h10000 - w)}));
      pb <= 50'(b * $signed({1'b0, w}));
      y  <= 32'(s >>> 16);
    end
  end

endmodule

// ===== rtl/value_noise_sample_core.sv =====
// ----------------------------------------------------------------------------
// value_noise_sample_core: 3-D cosine-interpolated value noise sample
// Scales a point, hashes eight corners, blends x/y/z and scales by amplitude.
// ----------------------------------------------------------------------------
//   channel | role   | beat contents
//   req     | sink   | coord_x/y/z, channel_seed, frequency, amplitude
//   rsp     | source | noise_value
//
// Fourteen-stage pipeline, one beat per cycle while rsp.ready does not stall it.
// Depth set by the corner hash multiplies and the three blend levels.
// rst clears the stage valid bits only.
// The whole pipeline holds while the output beat waits on rsp.ready.
// ----------------------------------------------------------------------------
module value_noise_sample_core (
  input  logic          clk,
  input  logic          rst,
  vns_req_if.sink       req,
  vns_rsp_if.source     rsp
);

  logic                            en;
  logic [vns_pkg::PIPE_DEPTH-1:0]  vld;
  logic [23:0]                     amp1;
  logic [31:0]                     seed1;
  logic [31:0]                     seed2;
  vns_pkg::side_t                  side [vns_pkg::SIDE_DEPTH];
  logic [31:0]                     ix, iy, iz;
  vns_pkg::weight_t                wx, wy, wz;
  vns_pkg::q30_t                   cv [8];
  vns_pkg::q30_t                   i1, i2, j1, j2, i3, j3, nz;
  logic signed [56:0]              prod;
  logic signed [57:0]              rnd;

  assign en        = !vld[vns_pkg::PIPE_DEPTH-1] || rsp.ready;
  assign req.ready = en;
  assign rsp.valid = vld[vns_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[vns_pkg::PIPE_DEPTH-2:0], req.valid};
    end
  end

  // weights enter side[] one stage after amp
  always_ff @(posedge clk) begin
    if (en) begin
      amp1    <= req.amplitude;
      seed1   <= 32'(req.channel_seed);
      seed2   <= seed1;
      side[0] <= '{wx: wx, wy: wy, wz: wz, amp: amp1};
      for (int i = 1; i < vns_pkg::SIDE_DEPTH; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  vns_axis u_ax (.clk, .en, .coord(req.coord_x), .freq(req.frequency), .ipart(ix), .w(wx));
  vns_axis u_ay (.clk, .en, .coord(req.coord_y), .freq(req.frequency), .ipart(iy), .w(wy));
  vns_axis u_az (.clk, .en, .coord(req.coord_z), .freq(req.frequency), .ipart(iz), .w(wz));

  for (genvar g = 0; g < 8; g++) begin : g_corner
    vns_hash u_hash (
      .clk, .en,
      .x(ix + 32'(g & 1)),
      .y(iy + 32'((g >> 1) & 1)),
      .z(iz + 32'((g >> 2) & 1)),
      .c(seed2),
      .value(cv[g])
    );
  end

  vns_lerp u_lx0 (.clk, .en, .a(cv[0]), .b(cv[1]), .w(side[3].wx), .y(i1));
  vns_lerp u_lx1 (.clk, .en, .a(cv[2]), .b(cv[3]), .w(side[3].wx), .y(i2));
  vns_lerp u_lx2 (.clk, .en, .a(cv[4]), .b(cv[5]), .w(side[3].wx), .y(j1));
  vns_lerp u_lx3 (.clk, .en, .a(cv[6]), .b(cv[7]), .w(side[3].wx), .y(j2));
  vns_lerp u_ly0 (.clk, .en, .a(i1), .b(i2), .w(side[5].wy), .y(i3));
  vns_lerp u_ly1 (.clk, .en, .a(j1), .b(j2), .w(side[5].wy), .y(j3));
  vns_lerp u_lz  (.clk, .en, .a(i3), .b(j3), .w(side[7].wz), .y(nz));

  assign rnd = 58'(prod) + 58'sd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      prod            <= nz * $signed({1'b0, side[10].amp});
      rsp.noise_value <= 27'(rnd >>> 30);
    end
  end

endmodule
